### src/rbst_pkg.sv
// ----------------------------------------------------------------------------
// rbst_pkg: shared types for the ray / box slab test
// Coordinate format, input and result word layouts, pipeline stage enables.
// ----------------------------------------------------------------------------
package rbst_pkg;

    // signed fixed point coordinate, FRAC_BITS_DEF fractional bits by default
    localparam int COORD_WIDTH   = 32;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    // one ray / box pair
    typedef struct packed {
        coord_t origin_x;
        coord_t origin_y;
        coord_t origin_z;
        coord_t recip_dir_x;
        coord_t recip_dir_y;
        coord_t recip_dir_z;
        coord_t box_low_x;
        coord_t box_low_y;
        coord_t box_low_z;
        coord_t box_high_x;
        coord_t box_high_y;
        coord_t box_high_z;
    } in_word_t;

    // one test result
    typedef struct packed {
        logic   hit;
        coord_t entry_distance;
    } out_word_t;

    // load enables for the per-axis slab stages
    typedef struct packed {
        logic diff;
        logic mult;
        logic scale;
    } stage_en_t;

endpackage

### src/rbst_slab.sv
// ----------------------------------------------------------------------------
// rbst_slab: slab entry and exit distances for one axis
// Three register stages: slab select and difference, multiply by the
// reciprocal direction, rescale toward zero with saturation.
// ----------------------------------------------------------------------------
module rbst_slab #(
    parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  rbst_pkg::stage_en_t en,
    input  rbst_pkg::coord_t    origin,
    input  rbst_pkg::coord_t    recip,
    input  rbst_pkg::coord_t    low,
    input  rbst_pkg::coord_t    high,
    output rbst_pkg::coord_t    t_near,
    output rbst_pkg::coord_t    t_far
);
    import rbst_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int PW = DW + CW;

    localparam logic signed [PW-1:0] SAT_MAX = {{(PW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [PW-1:0] SAT_MIN = {{(PW-CW+1){1'b1}}, {(CW-1){1'b0}}};
    localparam logic signed [PW-1:0] ROUND_BIAS = {{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

    // shift right toward zero, then clamp to the coordinate range
    function automatic coord_t scale_sat(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] biased;
        logic signed [PW-1:0] shifted;
        coord_t               res;
        biased  = p[PW-1] ? p + ROUND_BIAS : p;
        shifted = biased >>> FRAC_BITS;
        if (shifted > SAT_MAX)
        begin
            res = SAT_MAX[CW-1:0];
        end
        else if (shifted < SAT_MIN)
        begin
            res = SAT_MIN[CW-1:0];
        end
        else
        begin
            res = shifted[CW-1:0];
        end
        return res;
    endfunction

    logic signed [DW-1:0] near_diff_next, far_diff_next;
    logic signed [DW-1:0] near_diff_reg, far_diff_reg;
    coord_t               recip_reg;
    logic signed [PW-1:0] near_prod_reg, far_prod_reg;
    coord_t               near_dist_reg, far_dist_reg;

    // negative reciprocal swaps the near and far slabs
    always_comb
    begin
        if (recip[CW-1])
        begin
            near_diff_next = {high[CW-1], high} - {origin[CW-1], origin};
            far_diff_next  = {low[CW-1], low} - {origin[CW-1], origin};
        end
        else
        begin
            near_diff_next = {low[CW-1], low} - {origin[CW-1], origin};
            far_diff_next  = {high[CW-1], high} - {origin[CW-1], origin};
        end
    end

    // stage: differences
    always_ff @(posedge clk)
    begin
        if (en.diff)
        begin
            near_diff_reg <= near_diff_next;
            far_diff_reg  <= far_diff_next;
            recip_reg     <= recip;
        end
    end

    // stage: full products
    always_ff @(posedge clk)
    begin
        if (en.mult)
        begin
            near_prod_reg <= near_diff_reg * recip_reg;
            far_prod_reg  <= far_diff_reg * recip_reg;
        end
    end

    // stage: rescale and saturate
    always_ff @(posedge clk)
    begin
        if (en.scale)
        begin
            near_dist_reg <= scale_sat(near_prod_reg);
            far_dist_reg  <= scale_sat(far_prod_reg);
        end
    end

    assign t_near = near_dist_reg;
    assign t_far  = far_dist_reg;

endmodule

### src/ray_box_slab_test_core.sv
// ----------------------------------------------------------------------------
// ray_box_slab_test_core: ray versus axis-aligned box slab test
// Per-axis slab distances in three stages, then x/y and z interval overlap.
// ----------------------------------------------------------------------------
// stages: slab difference, product, rescale, x/y overlap, output register
// throughput: one ray / box word per cycle while out_ready holds high
//   or a stage is empty; each axis unit has one multiply stage per slab
// reset: clears all stage valid bits; data registers are not reset
module ray_box_slab_test_core #(
    parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rbst_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output rbst_pkg::out_word_t out_word
);
    import rbst_pkg::*;

    localparam int NUM_STAGES = 5;

    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES:0]   adv;
    stage_en_t             slab_en;

    coord_t x_near, x_far, y_near, y_far, z_near, z_far;

    logic   miss_xy_reg;
    coord_t tmin_reg, tmax_reg, z_near_reg, z_far_reg;
    logic   miss_xy_next;
    coord_t tmin_next, tmax_next;

    out_word_t out_word_reg, out_word_next;
    logic      miss_z;

    // stall chain: a stage loads when empty or when its word moves on
    always_comb
    begin
        adv[NUM_STAGES] = out_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        valid_next[0] = adv[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
            else
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign slab_en.diff  = adv[0];
    assign slab_en.mult  = adv[1];
    assign slab_en.scale = adv[2];

    // per-axis slab units
    rbst_slab #(.FRAC_BITS(FRAC_BITS)) u_slab_x (
        .clk    (clk),
        .en     (slab_en),
        .origin (in_word.origin_x),
        .recip  (in_word.recip_dir_x),
        .low    (in_word.box_low_x),
        .high   (in_word.box_high_x),
        .t_near (x_near),
        .t_far  (x_far)
    );

    rbst_slab #(.FRAC_BITS(FRAC_BITS)) u_slab_y (
        .clk    (clk),
        .en     (slab_en),
        .origin (in_word.origin_y),
        .recip  (in_word.recip_dir_y),
        .low    (in_word.box_low_y),
        .high   (in_word.box_high_y),
        .t_near (y_near),
        .t_far  (y_far)
    );

    rbst_slab #(.FRAC_BITS(FRAC_BITS)) u_slab_z (
        .clk    (clk),
        .en     (slab_en),
        .origin (in_word.origin_z),
        .recip  (in_word.recip_dir_z),
        .low    (in_word.box_low_z),
        .high   (in_word.box_high_z),
        .t_near (z_near),
        .t_far  (z_far)
    );

    // x/y overlap and narrowed interval
    always_comb
    begin
        miss_xy_next = (x_near > y_far) || (y_near > x_far);
        tmin_next    = (y_near > x_near) ? y_near : x_near;
        tmax_next    = (y_far < x_far) ? y_far : x_far;
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            miss_xy_reg <= miss_xy_next;
            tmin_reg    <= tmin_next;
            tmax_reg    <= tmax_next;
            z_near_reg  <= z_near;
            z_far_reg   <= z_far;
        end
    end

    // z overlap and final entry distance
    always_comb
    begin
        miss_z = miss_xy_reg || (tmin_reg > z_far_reg) || (z_near_reg > tmax_reg);
        out_word_next.hit = !miss_z;
        if (miss_z)
        begin
            out_word_next.entry_distance = '0;
        end
        else if (z_near_reg > tmin_reg)
        begin
            out_word_next.entry_distance = z_near_reg;
        end
        else
        begin
            out_word_next.entry_distance = tmin_reg;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[NUM_STAGES-1];
    assign out_word  = out_word_reg;

endmodule

### test/ray_box_slab_test_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_test_core_tb: self-checking bench for the ray / box slab test
// Drives a table of hand-picked ray / box pairs, then random pairs, mostly
// boxes near the ray, with bursts of idle and stall on both channels. Each
// result word is checked against its table word or an in-bench slab test.
// ----------------------------------------------------------------------------
module ray_box_slab_test_core_tb;

    import rbst_pkg::*;

    localparam int     N_RANDOM     = 1535;
    localparam int     N_CALM       = 150;
    localparam int     LONG_HOLD    = 120;
    localparam int     STUCK_LIMIT  = 1000;
    localparam int     MAX_REPORTS  = 10;
    localparam coord_t ONE          = 32'sh0001_0000;
    localparam coord_t C_MAX        = 32'sh7FFF_FFFF;
    localparam coord_t C_MIN        = 32'sh8000_0000;

    localparam logic signed [65:0] ROUND_ADJ = (66'sd1 <<< FRAC_BITS_DEF) - 66'sd1;
    localparam logic signed [65:0] SAT_HI    = 66'sd2147483647;
    localparam logic signed [65:0] SAT_LO    = -66'sd2147483648;

    typedef struct {
        in_word_t  pair;
        bit        known;
        out_word_t res;
    } probe_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_word;

    // what the sender is offering beside the word itself
    bit        pair_known;
    out_word_t pair_res;

    out_word_t ray_hits_due[$];
    probe_t    probes[$];
    int        bad_results;
    int        n_taken;
    int        stuck_cycles;
    bit        quiet;
    bit        calm;
    bit        held;

    ray_box_slab_test_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // (slab - origin) * recip, rescaled toward zero and saturated
    function automatic coord_t scaled_slab(coord_t slab, coord_t org, coord_t recip);
        logic signed [32:0] gap;
        logic signed [65:0] prod;
        logic signed [65:0] q;
        gap  = {slab[COORD_WIDTH-1], slab} - {org[COORD_WIDTH-1], org};
        prod = gap * recip;
        if (prod < 0)
            prod = prod + ROUND_ADJ;
        q = prod >>> FRAC_BITS_DEF;
        if (q > SAT_HI)
            return C_MAX;
        if (q < SAT_LO)
            return C_MIN;
        return q[COORD_WIDTH-1:0];
    endfunction

    // expected result word for one ray / box pair
    function automatic out_word_t slab_test(in_word_t w);
        coord_t    org[3];
        coord_t    rcp[3];
        coord_t    lo[3];
        coord_t    hi[3];
        coord_t    t_near[3];
        coord_t    t_far[3];
        coord_t    t_in;
        coord_t    t_out;
        out_word_t res;
        org = '{w.origin_x, w.origin_y, w.origin_z};
        rcp = '{w.recip_dir_x, w.recip_dir_y, w.recip_dir_z};
        lo  = '{w.box_low_x, w.box_low_y, w.box_low_z};
        hi  = '{w.box_high_x, w.box_high_y, w.box_high_z};
        for (int a = 0; a < 3; a++)
        begin
            // negative reciprocal: upper corner is the near slab
            if (rcp[a] < 0)
            begin
                t_near[a] = scaled_slab(hi[a], org[a], rcp[a]);
                t_far[a]  = scaled_slab(lo[a], org[a], rcp[a]);
            end
            else
            begin
                t_near[a] = scaled_slab(lo[a], org[a], rcp[a]);
                t_far[a]  = scaled_slab(hi[a], org[a], rcp[a]);
            end
        end
        res = '0;
        if (t_near[0] > t_far[1] || t_near[1] > t_far[0])
            return res;
        t_in  = (t_near[1] > t_near[0]) ? t_near[1] : t_near[0];
        t_out = (t_far[1] < t_far[0]) ? t_far[1] : t_far[0];
        if (t_in > t_far[2] || t_near[2] > t_out)
            return res;
        if (t_near[2] > t_in)
            t_in = t_near[2];
        res.hit            = 1'b1;
        res.entry_distance = t_in;
        return res;
    endfunction

    function automatic in_word_t pair_word(coord_t ox, coord_t oy, coord_t oz,
                                           coord_t rx, coord_t ry, coord_t rz,
                                           coord_t lx, coord_t ly, coord_t lz,
                                           coord_t hx, coord_t hy, coord_t hz);
        in_word_t w;
        w.origin_x    = ox;
        w.origin_y    = oy;
        w.origin_z    = oz;
        w.recip_dir_x = rx;
        w.recip_dir_y = ry;
        w.recip_dir_z = rz;
        w.box_low_x   = lx;
        w.box_low_y   = ly;
        w.box_low_z   = lz;
        w.box_high_x  = hx;
        w.box_high_y  = hy;
        w.box_high_z  = hz;
        return w;
    endfunction

    // same ray and slab on all three axes
    function automatic in_word_t cube_word(coord_t o, coord_t r, coord_t l, coord_t h);
        return pair_word(o, o, o, r, r, r, l, l, l, h, h, h);
    endfunction

    function automatic void add_probe(in_word_t w, bit known, bit hit, coord_t t_entry);
        probe_t p;
        p.pair               = w;
        p.known              = known;
        p.res.hit            = hit;
        p.res.entry_distance = t_entry;
        probes = {probes, p};
    endfunction

    // uniform in +/- units, full fractional resolution
    function automatic coord_t rand_near(int units);
        int span;
        span = units * 65536;
        return coord_t'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic coord_t rand_wild();
        case ($urandom_range(0, 3))
            0:       return C_MAX;
            1:       return C_MIN;
            2:       return rand_near(4);
            default: return coord_t'($urandom);
        endcase
    endfunction

    // mostly boxes near a ray from near the origin, the rest noise
    function automatic in_word_t rand_pair();
        coord_t o[3];
        coord_t r[3];
        coord_t l[3];
        coord_t h[3];
        bit     wild;
        wild = ($urandom_range(0, 9) >= 7);
        for (int a = 0; a < 3; a++)
        begin
            if (wild)
            begin
                o[a] = rand_wild();
                r[a] = rand_wild();
                l[a] = rand_wild();
                h[a] = rand_wild();
            end
            else
            begin
                o[a] = rand_near(16);
                r[a] = ($urandom_range(0, 7) == 0) ? coord_t'(0) : rand_near(4);
                l[a] = rand_near(16);
                h[a] = ($urandom_range(0, 15) == 0) ? rand_near(16)
                                                    : l[a] + coord_t'($urandom_range(0, 24 * 65536));
            end
        end
        return pair_word(o[0], o[1], o[2], r[0], r[1], r[2], l[0], l[1], l[2], h[0], h[1], h[2]);
    endfunction

    // hold one word on the input until it is taken
    task automatic offer_pair(input in_word_t w, input bit known, input out_word_t res);
        if (!calm && !quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_word    <= w;
        pair_known <= known;
        pair_res   <= res;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // stop offering until every result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ray_hits_due.size() != 0)
            @(posedge clk);
    endtask

    // score accepted words on both sides
    always @(posedge clk)
    begin
        out_word_t want;
        out_word_t due;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                due          = pair_known ? pair_res : slab_test(in_word);
                ray_hits_due = {ray_hits_due, due};
                n_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (ray_hits_due.size() == 0)
                begin
                    if (bad_results < MAX_REPORTS)
                        $display("unexpected result word: hit %0b entry %0d",
                                 out_word.hit, out_word.entry_distance);
                    bad_results++;
                end
                else
                begin
                    want = ray_hits_due.pop_front();
                    if (out_word.hit !== want.hit
                        || out_word.entry_distance !== want.entry_distance)
                    begin
                        if (bad_results < MAX_REPORTS)
                            $display("mismatch: hit exp %0b got %0b, entry exp %0d got %0d",
                                     want.hit, out_word.hit,
                                     want.entry_distance, out_word.entry_distance);
                        bad_results++;
                    end
                end
            end
        end
    end

    // end the run when neither side moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: short stall bursts, one long hold-off
    initial
    begin
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held && n_taken >= 400)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (!calm && !quiet && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // directed table
    initial
    begin
        add_probe(cube_word(0, 0, 0, 0), 1, 1'b1, 0);
        add_probe(cube_word(0, ONE, ONE, 2 * ONE), 1, 1'b1, ONE);
        add_probe(pair_word(0, 0, 0, ONE, ONE, ONE, ONE, 3 * ONE, 0,
                            2 * ONE, 4 * ONE, ONE), 1, 1'b0, 0);
        add_probe(cube_word(0, -ONE, -2 * ONE, -ONE), 1, 1'b1, ONE);
        add_probe(cube_word(C_MIN, C_MAX, C_MAX, C_MAX), 1, 1'b1, C_MAX);
        add_probe(cube_word(C_MIN, C_MIN, C_MAX, C_MAX), 1, 1'b1, C_MIN);
        // box behind the origin is still a hit
        add_probe(cube_word(10 * ONE, ONE, ONE, 2 * ONE), 1, 1'b1, -9 * ONE);
        // inverted box
        add_probe(cube_word(0, ONE, 2 * ONE, ONE), 1, 1'b0, 0);
        // z misses the narrowed x/y interval
        add_probe(pair_word(0, 0, 0, ONE, ONE, ONE, ONE, ONE, 5 * ONE,
                            2 * ONE, 2 * ONE, 6 * ONE), 1, 1'b0, 0);
        // z sets the entry
        add_probe(pair_word(0, 0, 0, ONE, ONE, ONE, ONE, ONE, 2 * ONE,
                            4 * ONE, 4 * ONE, 3 * ONE), 1, 1'b1, 2 * ONE);
        // z narrows the exit, x/y set the entry
        add_probe(pair_word(0, 0, 0, ONE, ONE, ONE, ONE, ONE, 0,
                            4 * ONE, 4 * ONE, 2 * ONE), 0, 1'b0, 0);
        // zero reciprocal on one axis
        add_probe(pair_word(0, 0, 0, 0, ONE, ONE, 5 * ONE, ONE, ONE,
                            6 * ONE, 2 * ONE, 2 * ONE), 0, 1'b0, 0);
        add_probe(pair_word(0, 0, 0, 0, ONE, ONE, -ONE, -ONE, -ONE,
                            ONE, ONE, ONE), 0, 1'b0, 0);
        add_probe(cube_word(-1, -1, -1, -1), 0, 1'b0, 0);
        add_probe(cube_word(C_MAX, C_MAX, C_MAX, C_MAX), 0, 1'b0, 0);
        add_probe(cube_word(C_MIN, C_MIN, C_MIN, C_MIN), 0, 1'b0, 0);
        add_probe(cube_word(32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA,
                            32'sh5555_5555), 0, 1'b0, 0);
        add_probe(cube_word(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                            32'shAAAA_AAAA), 0, 1'b0, 0);
        // rounding toward zero on small products
        add_probe(cube_word(3, -32'sh0000_8000, -5, 7), 0, 1'b0, 0);
        add_probe(cube_word(-7, 32'sh0000_8001, -4, 9), 0, 1'b0, 0);
        add_probe(pair_word(C_MIN, 0, C_MAX, C_MIN, C_MAX, -1, C_MAX, C_MIN, 0,
                            C_MAX, C_MAX, C_MIN), 0, 1'b0, 0);
    end

    // reset and stimulus
    initial
    begin
        out_word_t none;
        none       = '0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_word    <= '0;
        pair_known <= 1'b0;
        pair_res   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probes[i])
            offer_pair(probes[i].pair, probes[i].known, probes[i].res);
        wait_drained();

        for (int n = 0; n < N_RANDOM; n++)
        begin
            quiet = ((n / 200) % 4 == 3);
            calm  = (n >= N_RANDOM - N_CALM);
            if (n == 700)
                wait_drained();
            offer_pair(rand_pair(), 1'b0, none);
        end
        wait_drained();
        repeat (20) @(posedge clk);

        if (bad_results == 0 && ray_hits_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
